### hw/rtl/modexp_pkg.sv
`default_nettype none

package modexp_pkg;

  // Fixed widths of the words and registers
  localparam int OPW        = 31;        // base and result word
  localparam int PROD_W     = 2 * OPW;   // full product of two operands
  localparam int EXP_REG_W  = 32;        // exponent register
  localparam int MOD_REG_W  = 31;        // modulus register
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  // Defaults for the top-level parameters
  localparam int DEF_EXP_BITS = 32;
  localparam int DEF_MOD_BITS = 31;

  // Reduction retires two product bits per cycle
  localparam int RED_BITS   = 2;
  localparam int RED_CYCLES = PROD_W / RED_BITS;
  localparam int RED_CNT_W  = $clog2(RED_CYCLES);

  // Register index, taken from paddr[2]
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  localparam logic [MOD_REG_W-1:0] MODULUS_RESET = MOD_REG_W'(1);

  // Controller to datapath
  typedef struct packed {
    logic load;        // take a new base, exponent and modulus, set product to one
    logic mul_square;  // multiplier operands: base * base, else product * base
    logic mul_load;    // latch the product and clear the remainder
    logic red_step;    // retire two product bits into the remainder
    logic write_prod;  // remainder replaces the running product
    logic write_base;  // remainder replaces the base
    logic shift_exp;   // drop the exponent bit just used
  } modexp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
  } modexp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/modexp_ctrl.sv
`default_nettype none

module modexp_ctrl
  import modexp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire modexp_sts_t sts,
  output modexp_cmd_t      cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_MULT   = 6'b000100,
    ST_REDUCE = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic                 square, square_next;
  logic [RED_CNT_W-1:0] red_cnt, red_cnt_next;

  always_comb begin
    state_next   = state;
    square_next  = square;
    red_cnt_next = red_cnt;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.exp_zero) begin
          state_next = ST_DONE;
        end else begin
          square_next = !sts.exp_lsb;
          state_next  = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.mul_load   = 1'b1;
        cmd.mul_square = square;
        red_cnt_next   = '0;
        state_next     = ST_REDUCE;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
        red_cnt_next = red_cnt + RED_CNT_W'(1);
        if (red_cnt == RED_CNT_W'(RED_CYCLES - 1)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (square) begin
          cmd.write_base = 1'b1;
          cmd.shift_exp  = 1'b1;
          state_next     = ST_CHECK;
        end else begin
          cmd.write_prod = 1'b1;
          // skip the squaring after the top set bit
          if (sts.exp_rest_zero) begin
            state_next = ST_DONE;
          end else begin
            square_next = 1'b1;
            state_next  = ST_MULT;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      square  <= 1'b0;
      red_cnt <= '0;
    end else begin
      state   <= state_next;
      square  <= square_next;
      red_cnt <= red_cnt_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

### hw/rtl/modexp_dp.sv
`default_nettype none

module modexp_dp
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = DEF_EXP_BITS,
  parameter int MOD_BITS = DEF_MOD_BITS
) (
  input  wire logic                 clk,
  input  wire modexp_cmd_t          cmd,
  input  wire logic [OPW-1:0]       base_value,
  input  wire logic [EXP_REG_W-1:0] exponent_value,
  input  wire logic [MOD_REG_W-1:0] modulus_value,
  output modexp_sts_t               sts,
  output logic [OPW-1:0]            power_result
);

  localparam int EW = (EXP_BITS < EXP_REG_W) ? EXP_BITS : EXP_REG_W;

  logic [OPW-1:0]      base;
  logic [MOD_BITS-1:0] prod;
  logic [EXP_BITS-1:0] expo;
  logic [MOD_BITS:0]   mod_eff;
  logic [PROD_W-1:0]   mul_sh;
  logic [MOD_BITS-1:0] rem;

  logic [MOD_BITS-1:0] mod_low;
  logic [OPW-1:0]      mul_a;
  logic [MOD_BITS:0]   t1, t2, r1, r2;

  assign mod_low = modulus_value[MOD_BITS-1:0];
  assign mul_a   = cmd.mul_square ? base : OPW'(prod);

  // Two restoring steps: shift in a product bit, subtract the modulus if it fits
  always_comb begin
    t1 = {rem, mul_sh[PROD_W-1]};
    r1 = (t1 >= mod_eff) ? (t1 - mod_eff) : t1;
    t2 = {r1[MOD_BITS-1:0], mul_sh[PROD_W-2]};
    r2 = (t2 >= mod_eff) ? (t2 - mod_eff) : t2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base    <= base_value;
      prod    <= MOD_BITS'(1);
      expo    <= EXP_BITS'(exponent_value[EW-1:0]);
      mod_eff <= (mod_low == '0) ? {1'b1, {MOD_BITS{1'b0}}} : {1'b0, mod_low};
    end
    if (cmd.mul_load) begin
      mul_sh <= PROD_W'(mul_a) * PROD_W'(base);
      rem    <= '0;
    end
    if (cmd.red_step) begin
      mul_sh <= mul_sh << RED_BITS;
      rem    <= r2[MOD_BITS-1:0];
    end
    if (cmd.write_prod) begin
      prod <= rem;
    end
    if (cmd.write_base) begin
      base <= OPW'(rem);
    end
    if (cmd.shift_exp) begin
      expo <= expo >> 1;
    end
  end

  assign sts.exp_zero      = (expo == '0);
  assign sts.exp_lsb       = expo[0];
  assign sts.exp_rest_zero = ((expo >> 1) == '0);

  assign power_result = OPW'(prod);

endmodule

`default_nettype wire

### hw/rtl/modular_exponentiation.sv
`default_nettype none
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+------------------------------
// input     | start, busy (taken: start & !busy) | base_value [30:0]
// result    | done (one-cycle strobe)          | power_result [30:0]
// config    | APB: psel penable pwrite pready  | paddr [2:0], pwdata, prdata
//
// Each modular multiplication is a multiplier step, a restoring reducer
// retiring two product bits per cycle, and a write-back step. A zero exponent
// goes from the check straight to the result strobe. Reset is synchronous and
// clears the controller and the registers (exponent 0, modulus 1); done strobes
// each result for one cycle and the receiver cannot stall.

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int EXP_BITS = DEF_EXP_BITS,
  parameter int MOD_BITS = DEF_MOD_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OPW-1:0]    base_value,
  output logic                   busy,
  output logic                   done,
  output logic [OPW-1:0]         power_result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic [EXP_REG_W-1:0] exponent_value;
  logic [MOD_REG_W-1:0] modulus_value;
  logic                 reg_sel;
  logic                 cfg_write;

  modexp_cmd_t cmd;
  modexp_sts_t sts;

  // Configuration registers: word address from paddr[2]
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent_value <= '0;
      modulus_value  <= MODULUS_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_EXPONENT: exponent_value <= pwdata[EXP_REG_W-1:0];
        REG_MODULUS:  modulus_value  <= pwdata[MOD_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    case (reg_sel)
      REG_EXPONENT: prdata = APB_DW'(exponent_value);
      REG_MODULUS:  prdata = APB_DW'(modulus_value);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: walks the exponent bits and paces multiply and reduce
  modexp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath: base, product, exponent shifter, multiplier and reducer
  modexp_dp #(
    .EXP_BITS (EXP_BITS),
    .MOD_BITS (MOD_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .base_value     (base_value),
    .exponent_value (exponent_value),
    .modulus_value  (modulus_value),
    .sts            (sts),
    .power_result   (power_result)
  );

  // An accepted word always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");

  // The result strobe ends the work and frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && !done))
    else $error("block still busy after the result strobe");

  // A result strobe only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (busy && $past(busy)))
    else $error("result strobe without work in progress");

endmodule

`default_nettype wire
